// ===== rtl/rd_pkg.sv =====
package rd_pkg;

  localparam int unsigned DepthDef = 16;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // one stored record
  typedef struct packed {
    logic [63:0] id;
    logic [63:0] name_high;
    logic [63:0] name_low;
    logic [7:0]  age;
  } rec_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic rotate;
  } chain_cmd_t;

  // where a cell sits relative to the current fill level
  typedef struct packed {
    logic at_fill;
    logic at_tail;
  } cell_pos_t;

endpackage

// ===== rtl/rd_in_if.sv =====
interface rd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [63:0] student_id;
  logic [63:0] name_high;
  logic [63:0] name_low;
  logic [7:0]  age;

  modport source (
    output valid, op, student_id, name_high, name_low, age,
    input  ready
  );

  modport sink (
    input  valid, op, student_id, name_high, name_low, age,
    output ready
  );
endinterface

// ===== rtl/rd_out_if.sv =====
interface rd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        has_record;
  logic [63:0] out_id;
  logic [63:0] out_name_high;
  logic [63:0] out_name_low;
  logic [7:0]  out_age;
  logic        last;

  modport source (
    output valid, status, has_record, out_id, out_name_high, out_name_low, out_age, last,
    input  ready
  );

  modport sink (
    input  valid, status, has_record, out_id, out_name_high, out_name_low, out_age, last,
    output ready
  );
endinterface

// ===== rtl/rd_cell.sv =====
module rd_cell (
  input  logic                clk_i,
  input  rd_pkg::chain_cmd_t  cmd_i,
  input  rd_pkg::cell_pos_t   pos_i,
  input  rd_pkg::rec_t        load_i,
  input  rd_pkg::rec_t        left_i,
  input  rd_pkg::rec_t        right_i,
  input  rd_pkg::rec_t        wrap_i,
  output rd_pkg::rec_t        rec_o
);
  import rd_pkg::*;

  rec_t rec_d, rec_q;

  // select the neighbor or the new record for this cycle
  always_comb begin
    rec_d = rec_q;
    if (cmd_i.push_front) begin
      rec_d = left_i;
    end else if (cmd_i.push_back) begin
      if (pos_i.at_fill) begin
        rec_d = load_i;
      end
    end else if (cmd_i.pop_front) begin
      rec_d = right_i;
    end else if (cmd_i.rotate) begin
      rec_d = pos_i.at_tail ? wrap_i : right_i;
    end
  end

  // record storage, no reset needed
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ===== rtl/rd_ctrl.sv =====
module rd_ctrl #(
  parameter int unsigned DEPTH = rd_pkg::DepthDef,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rd_in_if.sink               in_i,
  rd_out_if.source            out_o,
  input  rd_pkg::rec_t        head_i,
  output rd_pkg::chain_cmd_t  cmd_o,
  output logic [CntW-1:0]     count_o
);
  import rd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_e;

  state_e          state_d, state_q;
  logic [CntW-1:0] count_d, count_q;
  logic [CntW-1:0] remain_d, remain_q;
  logic            ovalid_d, ovalid_q;
  logic [1:0]      status_d, status_q;
  logic            has_d, has_q;
  logic            last_d, last_q;
  rec_t            orec_d, orec_q;
  logic            slot_free, accept, empty, full;
  chain_cmd_t      cmd;

  assign slot_free = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign accept = in_i.valid && in_i.ready;
  assign empty = (count_q == '0);
  assign full = (count_q == CntW'(DEPTH));

  // operation decode and dump sequencing
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    remain_d = remain_q;
    ovalid_d = ovalid_q && !out_o.ready;
    status_d = status_q;
    has_d    = has_q;
    last_d   = last_q;
    orec_d   = orec_q;
    cmd      = '0;
    if (accept) begin
      ovalid_d = 1'b1;
      status_d = ST_OK;
      has_d    = 1'b0;
      last_d   = 1'b1;
      orec_d   = '0;
      case (in_i.op)
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.push_front = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.push_back = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.pop_front = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        OP_DUMP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ovalid_d = 1'b0;
            remain_d = count_q;
            state_d  = S_DUMP;
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == S_DUMP && slot_free) begin
      // one record per beat from the head, chain rotates behind it
      ovalid_d   = 1'b1;
      status_d   = ST_OK;
      has_d      = 1'b1;
      orec_d     = head_i;
      last_d     = (remain_q == CntW'(1));
      cmd.rotate = 1'b1;
      remain_d   = remain_q - 1'b1;
      if (remain_q == CntW'(1)) begin
        state_d = S_IDLE;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      remain_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      ovalid_q <= ovalid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    has_q    <= has_d;
    last_q   <= last_d;
    orec_q   <= orec_d;
  end

  assign cmd_o   = cmd;
  assign count_o = count_q;

  assign out_o.valid         = ovalid_q;
  assign out_o.status        = status_q;
  assign out_o.has_record    = has_q;
  assign out_o.out_id        = orec_q.id;
  assign out_o.out_name_high = orec_q.name_high;
  assign out_o.out_name_low  = orec_q.name_low;
  assign out_o.out_age       = orec_q.age;
  assign out_o.last          = last_q;

  // fill level stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(DEPTH))
    else $error("fill level above depth");

  // the fill level is frozen while a dump streams
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |=> count_q == $past(count_q))
    else $error("fill level changed during dump");

  // a dump always has records left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> remain_q != '0 && remain_q <= count_q)
    else $error("dump counter out of range");

  // at most one chain command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("conflicting chain commands");

  // a record beat always reports ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && has_q |-> status_q == ST_OK)
    else $error("record beat with error status");

endmodule

// ===== rtl/record_deque.sv =====
// record_deque: double-ended queue of records held in a chain of DEPTH cells
// push and pop: one input beat, one result beat on the next cycle, one beat per cycle while results are taken
// dump of n records: n result beats, one per cycle while the output is ready, the first registered after the
//   controller enters its dump state; input is held off while the chain rotates past its head cell
// reset (async, active low) empties the queue and clears the result valid; cell
//   contents are not reset
module record_deque #(
  parameter int unsigned DEPTH = rd_pkg::DepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rd_in_if.sink    in_i,
  rd_out_if.source out_o
);
  import rd_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  chain_cmd_t      cmd;
  logic [CntW-1:0] count;
  rec_t            load_rec;
  rec_t            cell_rec [DEPTH];

  assign load_rec.id        = in_i.student_id;
  assign load_rec.name_high = in_i.name_high;
  assign load_rec.name_low  = in_i.name_low;
  assign load_rec.age       = in_i.age;

  rd_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .head_i  (cell_rec[0]),
    .cmd_o   (cmd),
    .count_o (count)
  );

  // chain of record cells, cell 0 holds the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_pos_t pos;
    rec_t      left_rec;
    rec_t      right_rec;

    assign pos.at_fill = (count == CntW'(i));
    assign pos.at_tail = (count == CntW'(i + 1));

    if (i == 0) begin : g_first
      assign left_rec = load_rec;
    end else begin : g_inner
      assign left_rec = cell_rec[i-1];
    end

    if (i == DEPTH - 1) begin : g_lastc
      assign right_rec = cell_rec[i];
    end else begin : g_mid
      assign right_rec = cell_rec[i+1];
    end

    rd_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .load_i  (load_rec),
      .left_i  (left_rec),
      .right_i (right_rec),
      .wrap_i  (cell_rec[0]),
      .rec_o   (cell_rec[i])
    );
  end

endmodule
